// ===== rtl/core/gha_pkg.sv =====
// -----------------------------------------------------------------------------
// Generational handle allocator package
// Shared widths, command and status codes, and the types that pass between
// the allocator modules.
// -----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

   localparam int HANDLE_W  = 32;
   localparam int SLOT_W    = 20;
   localparam int VER_W     = 12;
   localparam int MAX_SLOTS = 1024;
   localparam int ADDR_W    = $clog2(MAX_SLOTS);
   localparam int USED_W    = $clog2(MAX_SLOTS + 1);
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;

   // All ones in the slot field marks the end of the free list.
   localparam logic [SLOT_W-1:0] NULL_SLOT = {SLOT_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 2'd0,
      CMD_DESTROY = 2'd1,
      CMD_CHECK   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_STALE = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Everything the execute stage decides for one command.
   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [HANDLE_W-1:0] wr_data;
      logic [USED_W-1:0]   slots_used;
      logic [SLOT_W-1:0]   free_head;
      logic [HANDLE_W-1:0] result_handle;
      logic                is_live;
      status_type          status;
   } exec_type;

endpackage

`default_nettype wire

// ===== rtl/core/gha_ram.sv =====
// -----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// -----------------------------------------------------------------------------
`default_nettype none

module gha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gha_exec.sv =====
// -----------------------------------------------------------------------------
// Allocator execute stage
// Decides result, table write-back and the new allocation counters for one
// command, given the slot entry that was read for it.
// -----------------------------------------------------------------------------
`default_nettype none

module gha_exec
   import gha_pkg::*;
(
   input  wire logic [CMD_W-1:0]    cmd,
   input  wire logic [HANDLE_W-1:0] handle,
   input  wire logic [HANDLE_W-1:0] entry,
   input  wire logic [USED_W-1:0]   slots_used,
   input  wire logic [SLOT_W-1:0]   free_head,
   output exec_type                 ex
);

   logic [SLOT_W-1:0] slot;
   logic [VER_W-1:0]  next_ver;
   logic [SLOT_W-1:0] used_ext;
   logic              live;
   logic              head_ok;
   logic              room;

   always_comb begin
      slot     = handle[SLOT_W-1:0];
      next_ver = handle[HANDLE_W-1:SLOT_W] + VER_W'(1);
      used_ext = SLOT_W'(slots_used);
      // A slot below slots_used is always below the table size.
      live     = (slot < used_ext) && (entry == handle);
      head_ok  = (free_head != NULL_SLOT) && (free_head < used_ext);
      room     = (slots_used != USED_W'(MAX_SLOTS));
   end

   always_comb begin
      ex.wr_en         = 1'b0;
      ex.wr_addr       = slot[ADDR_W-1:0];
      ex.wr_data       = {next_ver, free_head};
      ex.slots_used    = slots_used;
      ex.free_head     = free_head;
      ex.result_handle = handle;
      ex.is_live       = 1'b0;
      ex.status        = STATUS_OK;

      case (cmd_type'(cmd))
         CMD_CREATE: begin
            if (head_ok) begin
               // Pop the free list; the entry keeps the bumped version.
               ex.wr_en         = 1'b1;
               ex.wr_addr       = free_head[ADDR_W-1:0];
               ex.result_handle = {entry[HANDLE_W-1:SLOT_W], free_head};
               ex.wr_data       = {entry[HANDLE_W-1:SLOT_W], free_head};
               ex.free_head     = entry[SLOT_W-1:0];
            end else begin
               // An empty or corrupt list is cleared either way.
               ex.free_head = NULL_SLOT;
               if (room) begin
                  ex.wr_en         = 1'b1;
                  ex.wr_addr       = slots_used[ADDR_W-1:0];
                  ex.result_handle = HANDLE_W'(slots_used);
                  ex.wr_data       = HANDLE_W'(slots_used);
                  ex.slots_used    = slots_used + USED_W'(1);
               end else begin
                  ex.result_handle = HANDLE_W'(NULL_SLOT);
                  ex.status        = STATUS_FULL;
               end
            end
         end
         CMD_DESTROY: begin
            if (live) begin
               ex.wr_en     = 1'b1;
               ex.free_head = slot;
               ex.is_live   = 1'b1;
            end else begin
               ex.status = STATUS_STALE;
            end
         end
         CMD_CHECK: begin
            if (live) begin
               ex.is_live = 1'b1;
            end else begin
               ex.status = STATUS_STALE;
            end
         end
         default: begin
            ex.status = STATUS_STALE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/generational_handle_allocator_unit.sv =====
// -----------------------------------------------------------------------------
// Generational handle allocator
// Hands out and retires 32-bit handles (12-bit version, 20-bit slot) from a
// slot table held in one synchronous RAM, with a free list threaded through it.
// -----------------------------------------------------------------------------
// Usage:
//   The req channel carries one command per transfer: the command code in
//   req_tuser (create, destroy, check) and the handle in req_tdata. The rsp
//   channel returns exactly one result per command: the new or echoed handle
//   in rsp_tdata and the live flag and status code in rsp_tuser.
//   The slot table is read in the accept cycle and written back in the
//   execute state, when the result is registered; that state waits while
//   an earlier result is still held. No new command is taken until the
//   last one completes, since each is a single read-modify-write of the
//   slot table RAM, so no forwarding is needed.
//   The result register lets the next command be accepted while a result
//   waits; if the receiver still stalls when that command completes, the
//   block holds it and req_tready stays low until rsp_tready is seen.
//   Reset empties the free list and sets the fresh slot count to zero. The
//   table itself is not cleared: entries are only used after being written,
//   so the block is ready in the first cycle after reset.
// -----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator_unit
   import gha_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,   // [31:0] handle
   input  wire logic [1:0]    req_tuser,   // [1:0] command
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic      [31:0]   rsp_tdata,   // [31:0] result_handle
   output logic      [2:0]    rsp_tuser    // [0] is_live, [2:1] status
);

   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [USED_W-1:0]   slots_used_ff, slots_used_in;
   logic [SLOT_W-1:0]   free_head_ff, free_head_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_data_ff;
   logic [2:0]          rsp_user_ff;

   logic                req_fire;
   logic                exec_fire;
   logic [ADDR_W-1:0]   rd_addr;
   logic [HANDLE_W-1:0] rd_data;
   exec_type            ex;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      exec_fire  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = !reset;
         end
         S_EXEC: begin
            exec_fire = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign req_fire = req_tvalid && req_tready;

   // Create reads the free-list head, the other commands read the handle's slot.
   assign rd_addr = (cmd_type'(req_tuser) == CMD_CREATE) ? free_head_ff[ADDR_W-1:0]
                                                         : req_tdata[ADDR_W-1:0];

   gha_ram #(
      .WIDTH (HANDLE_W),
      .DEPTH (MAX_SLOTS)
   ) u_slot_table (
      .clock   (clock),
      .wr_en   (exec_fire && ex.wr_en),
      .wr_addr (ex.wr_addr),
      .wr_data (ex.wr_data),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gha_exec u_exec (
      .cmd        (cmd_ff),
      .handle     (handle_ff),
      .entry      (rd_data),
      .slots_used (slots_used_ff),
      .free_head  (free_head_ff),
      .ex         (ex)
   );

   always_comb begin
      slots_used_in = slots_used_ff;
      free_head_in  = free_head_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (exec_fire) begin
         slots_used_in = ex.slots_used;
         free_head_in  = ex.free_head;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slots_used_ff <= '0;
         free_head_ff  <= NULL_SLOT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slots_used_ff <= slots_used_in;
         free_head_ff  <= free_head_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= req_tuser;
         handle_ff <= req_tdata;
      end
      if (exec_fire) begin
         rsp_data_ff <= ex.result_handle;
         rsp_user_ff <= {ex.status, ex.is_live};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== sim/generational_handle_allocator_unit_checker.sv =====
// -----------------------------------------------------------------------------
// Generational handle allocator checker
// Watches the req and rsp channels, keeps its own slot table, free list and
// fresh slot count, predicts the result of every accepted command and compares
// each accepted result field by field with the oldest prediction.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_allocator_unit_checker
   import gha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] handle
   input  wire logic [1:0]  req_tuser,   // [1:0] command
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // [31:0] result_handle
   input  wire logic [2:0]  rsp_tuser,   // [0] is_live, [2:1] status
   output int               mismatches,
   output int               pending
);

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic                live;
      status_type          status;
   } alloc_result_type;

   logic [HANDLE_W-1:0] slot_map [0:MAX_SLOTS-1];
   int                  fresh_count;
   logic [SLOT_W-1:0]   free_top;
   alloc_result_type    expected_q [$];
   int                  bad_count = 0;
   int                  result_index = 0;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // Only slots below the fresh count have ever been written.
   function automatic logic handle_is_live(input logic [HANDLE_W-1:0] h);
      return (int'(h[SLOT_W-1:0]) < fresh_count) && (slot_map[int'(h[SLOT_W-1:0])] == h);
   endfunction

   function automatic alloc_result_type apply_command(input logic [1:0] cmd,
                                                      input logic [HANDLE_W-1:0] h);
      alloc_result_type    r;
      logic [HANDLE_W-1:0] entry;
      logic [VER_W-1:0]    next_ver;
      r.handle = h;
      r.live   = 1'b0;
      r.status = STATUS_OK;
      case (cmd)
         CMD_CREATE: begin
            if (free_top != NULL_SLOT && int'(free_top) >= fresh_count)
               free_top = NULL_SLOT;
            if (free_top != NULL_SLOT) begin
               entry = slot_map[int'(free_top)];
               r.handle = {entry[HANDLE_W-1:SLOT_W], free_top};
               slot_map[int'(free_top)] = r.handle;
               free_top = entry[SLOT_W-1:0];
            end else if (fresh_count < MAX_SLOTS) begin
               r.handle = HANDLE_W'(fresh_count);
               slot_map[fresh_count] = r.handle;
               fresh_count++;
            end else begin
               r.handle = {{VER_W{1'b0}}, NULL_SLOT};
               r.status = STATUS_FULL;
            end
         end
         CMD_DESTROY: begin
            if (handle_is_live(h)) begin
               next_ver = h[HANDLE_W-1:SLOT_W] + 1'b1;
               slot_map[int'(h[SLOT_W-1:0])] = {next_ver, free_top};
               free_top = h[SLOT_W-1:0];
               r.live = 1'b1;
            end else begin
               r.status = STATUS_STALE;
            end
         end
         CMD_CHECK: begin
            if (handle_is_live(h))
               r.live = 1'b1;
            else
               r.status = STATUS_STALE;
         end
         default: r.status = STATUS_STALE;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type want;
      alloc_result_type got;
      if (reset) begin
         fresh_count = 0;
         free_top = NULL_SLOT;
         expected_q.delete();
      end else begin
         // The result of this edge always belongs to an earlier command.
         if (rsp_tvalid && rsp_tready) begin
            got.handle = rsp_tdata;
            got.live   = rsp_tuser[0];
            got.status = status_type'(rsp_tuser[2:1]);
            if (expected_q.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("result %0d arrived with nothing outstanding: handle %h tuser %b",
                           result_index, rsp_tdata, rsp_tuser);
            end else begin
               want = expected_q.pop_front();
               if (got.handle !== want.handle || got.live !== want.live ||
                   got.status !== want.status) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display({"result %0d mismatch: handle exp %h got %h, live exp %0d ",
                               "got %0d, status exp %0d got %0d"}, result_index,
                              want.handle, got.handle, want.live, got.live,
                              want.status, got.status);
               end
            end
            result_index++;
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(apply_command(req_tuser, req_tdata));
      end
      mismatches <= bad_count;
      pending    <= expected_q.size();
   end

endmodule

// ===== sim/generational_handle_allocator_unit_tb.sv =====
// -----------------------------------------------------------------------------
// Generational handle allocator testbench
// Drives a short directed sequence, a long random mix of create, destroy and
// check commands that fills the table, and a create/destroy churn on one
// slot that walks its version upward. A separate checker predicts and
// compares every result; this module makes stimulus and gives the verdict.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module generational_handle_allocator_unit_tb;
   import gha_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam int RANDOM_ITEMS = 1600;
   localparam int CHURN_ROUNDS = 150;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int          mismatches;
   int          pending;
   int          cycles = 0;
   bit          gaps_on = 1'b1;

   // Handles handed out by successful creates and not yet destroyed here,
   // and handles this testbench has destroyed.
   logic [31:0] live_pool [$];
   logic [31:0] retired_pool [$];

   generational_handle_allocator_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   generational_handle_allocator_unit_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= !gaps_on || ($urandom_range(99) >= 21);

   // A successful create is the only result with status ok and no live flag.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready && rsp_tuser == {STATUS_OK, 1'b0})
         live_pool.push_back(rsp_tdata);

   task automatic send_command(input logic [1:0] cmd, input logic [31:0] h);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= h;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic choose_handle(input bit retire, output logic [31:0] h);
      int roll;
      int idx;
      roll = $urandom_range(99);
      if (roll < 60 && live_pool.size() > 0) begin
         idx = $urandom_range(live_pool.size() - 1);
         h = live_pool[idx];
         if (retire) begin
            retired_pool.push_back(h);
            live_pool.delete(idx);
         end
      end else if (roll < 75 && retired_pool.size() > 0) begin
         h = retired_pool[$urandom_range(retired_pool.size() - 1)];
      end else if (roll < 85 && live_pool.size() > 0) begin
         // Right slot, wrong version.
         h = live_pool[$urandom_range(live_pool.size() - 1)] ^
             {12'($urandom_range(4095, 1)), 20'h0};
      end else if (roll < 93) begin
         h = {12'($urandom), 20'($urandom_range(MAX_SLOTS - 1))};
      end else begin
         h = $urandom;
      end
   endtask

   initial begin
      logic [31:0] h;
      int          roll;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, unused code, first creates, stale and aliased
      // handles, double destroy, free list reuse in last-in first-out order.
      send_command(CMD_CHECK,    32'h0000_0000);
      send_command(CMD_DESTROY,  32'hFFFF_FFFF);
      send_command(CMD_RESERVED, 32'hFFFF_FFFF);
      send_command(CMD_CREATE,   32'hFFFF_FFFF);
      send_command(CMD_CREATE,   32'h0000_0000);
      send_command(CMD_CREATE,   32'hA5A5_5A5A);
      send_command(CMD_CHECK,    32'h0000_0000);
      send_command(CMD_CHECK,    32'h0010_0000);
      send_command(CMD_CHECK,    32'h0000_0400);
      send_command(CMD_DESTROY,  32'h0000_0001);
      send_command(CMD_DESTROY,  32'h0000_0001);
      send_command(CMD_CHECK,    32'h0000_0001);
      send_command(CMD_CHECK,    32'h001F_FFFF);
      send_command(CMD_DESTROY,  32'h0000_0000);
      send_command(CMD_CREATE,   32'h0000_0000);
      send_command(CMD_CREATE,   32'h0000_0000);
      send_command(CMD_CREATE,   32'h0000_0000);
      send_command(CMD_CHECK,    32'h0010_0001);
      send_command(CMD_DESTROY,  32'h0010_0001);
      send_command(CMD_CHECK,    32'hFFF0_0002);
      send_command(CMD_RESERVED, 32'h0000_0000);
      wait_all_results();
      live_pool.delete();

      // Random: create heavy so that the table fills and creates start to
      // report full before the end of this phase.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         gaps_on = !(i >= 800 && i < 1100);
         roll = $urandom_range(99);
         if (roll < 75) begin
            send_command(CMD_CREATE, $urandom);
         end else if (roll < 83) begin
            choose_handle(1'b1, h);
            send_command(CMD_DESTROY, h);
         end else if (roll < 96) begin
            choose_handle(1'b0, h);
            send_command(CMD_CHECK, h);
         end else begin
            send_command(CMD_RESERVED, $urandom);
         end
      end
      wait_all_results();

      // Churn one slot through a run of versions. A destroyed slot heads the
      // free list, so the next create hands it back one version higher.
      h = (live_pool.size() > 0) ? live_pool[$] : 32'h0000_0000;
      for (int i = 0; i < CHURN_ROUNDS; i++) begin
         send_command(CMD_DESTROY, h);
         if (i % 50 == 0)
            send_command(CMD_CHECK, h);
         h[31:20] = h[31:20] + 1'b1;
         send_command(CMD_CREATE, $urandom);
         if (i % 50 == 0)
            send_command(CMD_CHECK, h);
      end

      wait_all_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
